>>> hdl/tshp_pkg.sv
// ----------------------------------------------------------------------------
// Two-sum pair finder package
// Entry format of the slot memory, hash constants and the hash mixing steps.
// ----------------------------------------------------------------------------
package tshp_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 10;
    localparam int EP_W   = 4;

    localparam logic [EP_W-1:0]   EP_MAX  = '1;
    localparam logic [DATA_W-1:0] HASH_C1 = 32'h85eb_ca6b;
    localparam logic [DATA_W-1:0] HASH_C2 = 32'hc2b2_ae35;
    localparam int                SHIFT_A = 16;
    localparam int                SHIFT_B = 13;

    typedef struct packed {
        logic [EP_W-1:0]   epoch;
        logic [DATA_W-1:0] key;
        logic [IDX_W-1:0]  index;
    } entry_t;

    function automatic logic [DATA_W-1:0] hash_fold_a(input logic [DATA_W-1:0] k);
        return k ^ (k >> SHIFT_A);
    endfunction

    function automatic logic [DATA_W-1:0] hash_fold_b(input logic [DATA_W-1:0] k);
        return k ^ (k >> SHIFT_B);
    endfunction

endpackage

>>> hdl/two_sum_hash_pair_finder.sv
// ----------------------------------------------------------------------------
// Two-sum hash pair finder
// Hash table with linear probing that reports the first pair of stream values
// whose sum equals the programmed target.
// ----------------------------------------------------------------------------
// One item is handled at a time. Each item first passes DISPATCH; when the
// list is done or too long it goes straight to RESULT. Else its value is
// hashed and probed for a lookup, and a hit goes to RESULT; on a miss the
// key target - value is hashed and probed for an insert. The next transfer
// is taken in the cycle after the result is loaded, and a result that
// still waits on m_ready holds the item back. Each probe is one read of
// the single slot memory and one compare, and each hash runs through two
// registered multiplies and a registered slot address. Slot validity is an
// epoch mark kept with each entry; after reset, and on every fifteenth
// start, a clearing pass sweeps the memory before the next transfer is
// taken. TABLE_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module two_sum_hash_pair_finder
    import tshp_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic signed [DATA_W-1:0] cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_start_req,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_found,
    output logic [IDX_W-1:0]         m_current_index,
    output logic [IDX_W-1:0]         m_partner_index,
    output logic                     m_overflow,
    output logic                     m_finished
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = ADDR_W + 1;
    localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(TABLE_DEPTH - 1);

    typedef enum logic [3:0] {
        IDLE,
        CLEAR,
        DISPATCH,
        HASH_A,
        HASH_B,
        HASH_C,
        PROBE_RD,
        PROBE_CHK,
        RESULT
    } state_t;

    state_t                     state_reg;
    logic                       clr_resume_reg;
    logic [ADDR_W-1:0]          slot_reg;
    logic [CNT_W-1:0]           probe_n_reg;
    logic [EP_W-1:0]            epoch_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       done_reg;
    logic                       insert_reg;
    logic signed [DATA_W-1:0]   target_reg;
    logic signed [DATA_W-1:0]   value_reg;
    logic [DATA_W-1:0]          key_reg;
    logic [DATA_W-1:0]          prod1_reg;
    logic [DATA_W-1:0]          prod2_reg;
    logic                       res_found_reg;
    logic [IDX_W-1:0]           res_cur_reg;
    logic [IDX_W-1:0]           res_partner_reg;
    logic                       res_ovf_reg;
    logic                       res_fin_reg;
    logic                       m_valid_reg;
    logic                       m_found_reg;
    logic [IDX_W-1:0]           m_cur_reg;
    logic [IDX_W-1:0]           m_partner_reg;
    logic                       m_ovf_reg;
    logic                       m_fin_reg;

    entry_t                     slot_mem [TABLE_DEPTH];
    entry_t                     mem_rd_data_reg;
    logic                       mem_rd_en;
    logic                       mem_wr_en;
    logic [ADDR_W-1:0]          mem_wr_addr;
    entry_t                     mem_wr_data;

    logic [CNT_W+IDX_W-1:0]     count_ext;
    logic [IDX_W-1:0]           cur_idx;
    logic [DATA_W-1:0]          hash_word;
    logic                       entry_live;
    logic                       take_slot;
    logic [DATA_W-1:0]          insert_key;
    logic                       res_load;

    assign count_ext  = {{IDX_W{1'b0}}, count_reg};
    assign cur_idx    = count_ext[IDX_W-1:0];
    assign hash_word  = hash_fold_a(prod2_reg);
    assign entry_live = (mem_rd_data_reg.epoch == epoch_reg);
    assign take_slot  = !entry_live || (mem_rd_data_reg.key == key_reg);
    assign insert_key = DATA_W'(target_reg - value_reg);
    assign res_load   = (state_reg == RESULT) && (!m_valid_reg || m_ready);

    assign s_ready         = (state_reg == IDLE);
    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_current_index = m_cur_reg;
    assign m_partner_index = m_partner_reg;
    assign m_overflow      = m_ovf_reg;
    assign m_finished      = m_fin_reg;

    always_comb begin
        mem_rd_en   = (state_reg == PROBE_RD);
        mem_wr_en   = 1'b0;
        mem_wr_addr = slot_reg;
        mem_wr_data = '0;
        if (state_reg == CLEAR) begin
            mem_wr_en = 1'b1;
        end else if (state_reg == PROBE_CHK && insert_reg && take_slot) begin
            mem_wr_en         = 1'b1;
            mem_wr_data.epoch = epoch_reg;
            mem_wr_data.key   = key_reg;
            mem_wr_data.index = res_cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            slot_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            mem_rd_data_reg <= slot_mem[slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= CLEAR;
            clr_resume_reg <= 1'b0;
            slot_reg       <= '0;
            probe_n_reg    <= '0;
            epoch_reg      <= '0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            insert_reg     <= 1'b0;
            target_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                target_reg <= cfg_wr_data;
            end
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        value_reg <= s_value;
                        if (s_start_req) begin
                            count_reg <= '0;
                            done_reg  <= 1'b0;
                            if (epoch_reg == EP_MAX) begin
                                slot_reg       <= '0;
                                clr_resume_reg <= 1'b1;
                                state_reg      <= CLEAR;
                            end else begin
                                epoch_reg <= epoch_reg + EP_W'(1);
                                state_reg <= DISPATCH;
                            end
                        end else begin
                            state_reg <= DISPATCH;
                        end
                    end
                end
                CLEAR: begin
                    slot_reg <= slot_reg + ADDR_W'(1);
                    if (slot_reg == ADDR_MAX) begin
                        epoch_reg <= EP_W'(1);
                        state_reg <= clr_resume_reg ? DISPATCH : IDLE;
                    end
                end
                DISPATCH: begin
                    res_found_reg   <= 1'b0;
                    res_partner_reg <= '0;
                    res_ovf_reg     <= 1'b0;
                    res_fin_reg     <= 1'b0;
                    res_cur_reg     <= '0;
                    if (done_reg) begin
                        res_fin_reg <= 1'b1;
                        state_reg   <= RESULT;
                    end else if (count_reg == CNT_FULL) begin
                        res_ovf_reg <= 1'b1;
                        state_reg   <= RESULT;
                    end else begin
                        res_cur_reg <= cur_idx;
                        key_reg     <= value_reg;
                        insert_reg  <= 1'b0;
                        state_reg   <= HASH_A;
                    end
                end
                HASH_A: begin
                    prod1_reg <= hash_fold_a(key_reg) * HASH_C1;
                    state_reg <= HASH_B;
                end
                HASH_B: begin
                    prod2_reg <= hash_fold_b(prod1_reg) * HASH_C2;
                    state_reg <= HASH_C;
                end
                HASH_C: begin
                    slot_reg    <= hash_word[ADDR_W-1:0];
                    probe_n_reg <= '0;
                    state_reg   <= PROBE_RD;
                end
                PROBE_RD: begin
                    state_reg <= PROBE_CHK;
                end
                PROBE_CHK: begin
                    if (take_slot) begin
                        if (!insert_reg) begin
                            if (entry_live) begin
                                res_found_reg   <= 1'b1;
                                res_partner_reg <= mem_rd_data_reg.index;
                                done_reg        <= 1'b1;
                                count_reg       <= count_reg + CNT_W'(1);
                                state_reg       <= RESULT;
                            end else begin
                                key_reg    <= insert_key;
                                insert_reg <= 1'b1;
                                state_reg  <= HASH_A;
                            end
                        end else begin
                            count_reg <= count_reg + CNT_W'(1);
                            state_reg <= RESULT;
                        end
                    end else if (probe_n_reg == CNT_LAST) begin
                        if (!insert_reg) begin
                            key_reg    <= insert_key;
                            insert_reg <= 1'b1;
                            state_reg  <= HASH_A;
                        end else begin
                            res_ovf_reg <= 1'b1;
                            count_reg   <= count_reg + CNT_W'(1);
                            state_reg   <= RESULT;
                        end
                    end else begin
                        slot_reg    <= slot_reg + ADDR_W'(1);
                        probe_n_reg <= probe_n_reg + CNT_W'(1);
                        state_reg   <= PROBE_RD;
                    end
                end
                RESULT: begin
                    if (res_load) begin
                        m_found_reg   <= res_found_reg;
                        m_cur_reg     <= res_cur_reg;
                        m_partner_reg <= res_partner_reg;
                        m_ovf_reg     <= res_ovf_reg;
                        m_fin_reg     <= res_fin_reg;
                        state_reg     <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("Input transfer taken while an item is in progress.");

    a_found_not_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_finished))
        else $error("Result reports a pair after the list was finished.");

    a_found_not_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_overflow))
        else $error("Result reports both a pair and an overflow.");

    a_no_read_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_rd_en && mem_wr_en))
        else $error("Slot memory read and written in the same cycle.");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("Item count ran past the table depth.");
`endif

endmodule
